### sv/afcc_pkg.sv
// Shared types and constants of the box frustum and clip-plane culler.
`default_nettype none
package afcc_pkg;

    // Field widths fixed by the item format
    localparam int VAL_W    = 32;               // Q16.16 coordinate or coefficient
    localparam int COEF_W   = VAL_W + 1;        // row sum or difference
    localparam int PROD_W   = COEF_W + VAL_W;   // exact product
    localparam int ACC_W    = PROD_W + 3;       // three products plus scaled offset
    localparam int SLOT_W   = 3;
    localparam int CPLANE_W = 4;                // holds a clip plane index up to 15

    localparam int DEF_MAX_CLIP_PLANES = 8;
    localparam int DEF_FRAC_BITS       = 16;

    // Item kinds
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_LOAD_MAT  = 2'd0;
    localparam t_kind KIND_LOAD_CLIP = 2'd1;
    localparam t_kind KIND_TEST      = 2'd2;

    // Result causes
    typedef logic [1:0] t_cause;
    localparam t_cause CAUSE_NONE    = 2'd0;
    localparam t_cause CAUSE_FRUSTUM = 2'd1;
    localparam t_cause CAUSE_CLIP    = 2'd2;

    // Sequencer steps within one plane
    localparam logic [1:0] STEP_FIRST = 2'd0;
    localparam logic [1:0] STEP_MID1  = 2'd1;
    localparam logic [1:0] STEP_MID2  = 2'd2;
    localparam logic [1:0] STEP_LAST  = 2'd3;

    localparam logic [2:0] FPLANE_LAST = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FRUST,
        ST_CLIP,
        ST_RESULT
    } t_state;

    // Write request into the plane store
    typedef struct packed {
        logic                        mat_we;
        logic                        clip_we;
        logic [SLOT_W-1:0]           slot;
        logic                        flag;
        logic [3:0][VAL_W-1:0]       val;
    } t_load;

    // Which plane coefficient the sequencer wants
    typedef struct packed {
        logic                is_clip;
        logic [2:0]          fplane;
        logic [CPLANE_W-1:0] cplane;
        logic [1:0]          axis;
    } t_sel;

    // Multiply-accumulate controls
    typedef struct packed {
        logic load_off;
        logic mul;
        logic acc;
    } t_mac_ctl;

endpackage
`default_nettype wire

### sv/afcc_store.sv
// Plane store: view-projection matrix, clip planes and coefficient selection.
`default_nettype none
module afcc_store #(
    parameter int MAX_CLIP_PLANES = afcc_pkg::DEF_MAX_CLIP_PLANES
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  afcc_pkg::t_load                       i_load,
    input  afcc_pkg::t_sel                        i_sel,
    output logic signed [afcc_pkg::COEF_W-1:0]    o_coef,
    output logic signed [afcc_pkg::COEF_W-1:0]    o_off,
    output logic                                  o_enabled
);
    import afcc_pkg::*;

    localparam int IDX_W = (MAX_CLIP_PLANES > 1) ? $clog2(MAX_CLIP_PLANES) : 1;
    localparam int SEXT_W = 5;

    // r_mat[column][row]
    logic [VAL_W-1:0] r_mat [4][4];
    logic [VAL_W-1:0] r_nx  [MAX_CLIP_PLANES];
    logic [VAL_W-1:0] r_ny  [MAX_CLIP_PLANES];
    logic [VAL_W-1:0] r_nz  [MAX_CLIP_PLANES];
    logic [VAL_W-1:0] r_off [MAX_CLIP_PLANES];
    logic [MAX_CLIP_PLANES-1:0] r_en;

    logic [SEXT_W-1:0] w_slot_ext;
    logic              w_clip_ok;
    logic [IDX_W-1:0]  w_widx;
    logic [IDX_W-1:0]  w_ridx;
    logic [1:0]        w_row;
    logic signed [COEF_W-1:0] w_a, w_b, w_oa, w_ob, w_cn;

    assign w_slot_ext = SEXT_W'(i_load.slot);
    assign w_clip_ok  = w_slot_ext < SEXT_W'(MAX_CLIP_PLANES);
    assign w_widx     = w_slot_ext[IDX_W-1:0];
    assign w_ridx     = i_sel.cplane[IDX_W-1:0];

    // Matrix resets to zero since it is read as soon as the camera is on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < 4; c++) begin
                for (int r = 0; r < 4; r++) begin
                    r_mat[c][r] <= '0;
                end
            end
        end else if (i_load.mat_we && !i_load.slot[2]) begin
            for (int r = 0; r < 4; r++) begin
                r_mat[i_load.slot[1:0]][r] <= i_load.val[r];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en <= '0;
        end else if (i_load.clip_we && w_clip_ok) begin
            r_en[w_widx] <= i_load.flag;
        end
    end

    // Plane data only read once enabled, so no reset
    always_ff @(posedge i_clk) begin
        if (i_load.clip_we && w_clip_ok) begin
            r_nx[w_widx]  <= i_load.val[0];
            r_ny[w_widx]  <= i_load.val[1];
            r_nz[w_widx]  <= i_load.val[2];
            r_off[w_widx] <= i_load.val[3];
        end
    end

    // Frustum plane: row 3 plus/minus row (fplane / 2)
    assign w_row = i_sel.fplane[2:1];
    assign w_a   = COEF_W'($signed(r_mat[i_sel.axis][3]));
    assign w_b   = COEF_W'($signed(r_mat[i_sel.axis][w_row]));
    assign w_oa  = COEF_W'($signed(r_mat[3][3]));
    assign w_ob  = COEF_W'($signed(r_mat[3][w_row]));

    always_comb begin
        case (i_sel.axis)
            2'd0:    w_cn = COEF_W'($signed(r_nx[w_ridx]));
            2'd1:    w_cn = COEF_W'($signed(r_ny[w_ridx]));
            2'd2:    w_cn = COEF_W'($signed(r_nz[w_ridx]));
            default: w_cn = '0;
        endcase
    end

    always_comb begin
        if (i_sel.is_clip) begin
            o_coef = w_cn;
            o_off  = COEF_W'($signed(r_off[w_ridx]));
        end else if (i_sel.fplane[0]) begin
            o_coef = w_a - w_b;
            o_off  = w_oa - w_ob;
        end else begin
            o_coef = w_a + w_b;
            o_off  = w_oa + w_ob;
        end
    end

    assign o_enabled = r_en[w_ridx];

endmodule
`default_nettype wire

### sv/afcc_mac.sv
// Shared multiply-accumulate unit with plane sign test.
`default_nettype none
module afcc_mac #(
    parameter int FRAC_BITS = afcc_pkg::DEF_FRAC_BITS
) (
    input  wire                                  i_clk,
    input  afcc_pkg::t_mac_ctl                   i_ctl,
    input  wire signed [afcc_pkg::COEF_W-1:0]    i_coef,
    input  wire signed [afcc_pkg::VAL_W-1:0]     i_coord,
    input  wire signed [afcc_pkg::COEF_W-1:0]    i_off,
    output logic                                 o_below
);
    import afcc_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  w_off;
    logic signed [ACC_W-1:0]  w_sum;

    // Offset brought into the product scale
    assign w_off = {{(ACC_W-COEF_W-FRAC_BITS){i_off[COEF_W-1]}}, i_off, {FRAC_BITS{1'b0}}};
    assign w_sum = r_acc + ACC_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            r_prod <= i_coef * i_coord;
        end
        if (i_ctl.load_off) begin
            r_acc <= w_off;
        end else if (i_ctl.acc) begin
            r_acc <= w_sum;
        end
    end

    // Exact sum, so its sign bit is the "< 0" test
    assign o_below = w_sum[ACC_W-1];

endmodule
`default_nettype wire

### sv/aabb_frustum_clip_culler.sv
// Top level: box culler against six frustum planes and user clip planes.
//
// Load items (tuser kind 0/1) write a matrix column or a clip plane and are
// taken with no result. A test item (kind 2) gives exactly one result item.
// Planes are tested one after another on a single 33x32 multiplier and
// 68-bit accumulator: a plane that is tested goes through three products,
// then the final add and sign check; a disabled clip plane is passed over
// with no products. After the planes, a test item's result is handed to the
// output register and is valid on the cycle after that hand-off.
// Testing stops at the first plane that culls. An invalid box (flag clear) goes
// straight to the result, not culled.
// s_axis_tready is low from acceptance of a test item until its result has
// moved into the output register; a result waiting there for the receiver
// holds up only the hand-off of the next test's result, not the input.
// All sums are exact, there is no rounding or saturation.
`default_nettype none
module aabb_frustum_clip_culler #(
    parameter int MAX_CLIP_PLANES = afcc_pkg::DEF_MAX_CLIP_PLANES,
    parameter int FRAC_BITS       = afcc_pkg::DEF_FRAC_BITS
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    // configuration: camera_enable
    input  wire          i_cfg_wr_en,
    input  wire          i_cfg_wr_data,
    // input items
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // [2:0] slot, [3] flag, [35:4] value_a, [67:36] value_b, [99:68] value_c,
    // [131:100] value_d, [163:132] value_e, [195:164] value_f, [199:196] zero
    input  wire  [199:0] s_axis_tdata,
    // [1:0] kind
    input  wire  [1:0]   s_axis_tuser,
    // result items
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // [0] culled, [2:1] cull_cause, [7:3] zero
    output logic [7:0]   m_axis_tdata
);
    import afcc_pkg::*;

    localparam int IDX_W = (MAX_CLIP_PLANES > 1) ? $clog2(MAX_CLIP_PLANES) : 1;

    t_state r_state, n_state;
    logic [1:0]       r_step,   n_step;
    logic [2:0]       r_fplane, n_fplane;
    logic [IDX_W-1:0] r_cplane, n_cplane;
    t_cause           r_cause,  n_cause;
    logic             r_camera;
    logic [VAL_W-1:0] r_lo [3];
    logic [VAL_W-1:0] r_hi [3];
    logic             r_ovalid;
    logic [2:0]       r_odata;

    logic        w_in_acc;
    t_kind       w_kind;
    logic [2:0]  w_slot;
    logic        w_flag;
    logic [VAL_W-1:0] w_val [6];
    t_load       w_load;
    t_sel        w_sel;
    t_mac_ctl    w_mac;
    logic signed [COEF_W-1:0] w_coef, w_off;
    logic signed [VAL_W-1:0]  w_coord;
    logic        w_en, w_below, w_clast, w_active;
    logic        w_out_free;

    // Input unpacking
    assign w_kind = s_axis_tuser;
    assign w_slot = s_axis_tdata[2:0];
    assign w_flag = s_axis_tdata[3];
    for (genvar g = 0; g < 6; g++) begin : g_val
        assign w_val[g] = s_axis_tdata[4 + g*VAL_W +: VAL_W];
    end

    assign w_in_acc = s_axis_tvalid && s_axis_tready;

    assign w_load.mat_we  = w_in_acc && (w_kind == KIND_LOAD_MAT);
    assign w_load.clip_we = w_in_acc && (w_kind == KIND_LOAD_CLIP);
    assign w_load.slot    = w_slot;
    assign w_load.flag    = w_flag;
    assign w_load.val     = {w_val[3], w_val[2], w_val[1], w_val[0]};

    assign w_sel.is_clip = (r_state == ST_CLIP);
    assign w_sel.fplane  = r_fplane;
    assign w_sel.cplane  = CPLANE_W'(r_cplane);
    assign w_sel.axis    = r_step;

    assign w_clast = (r_cplane == IDX_W'(MAX_CLIP_PLANES - 1));

    // Output register free now or emptied at this edge
    assign w_out_free = !r_ovalid || m_axis_tready;

    // Corner on the normal's side: max where the component is >= 0
    always_comb begin
        case (r_step)
            STEP_FIRST: w_coord = w_coef[COEF_W-1] ? r_lo[0] : r_hi[0];
            STEP_MID1:  w_coord = w_coef[COEF_W-1] ? r_lo[1] : r_hi[1];
            STEP_MID2:  w_coord = w_coef[COEF_W-1] ? r_lo[2] : r_hi[2];
            default:    w_coord = '0;
        endcase
    end

    afcc_store #(
        .MAX_CLIP_PLANES (MAX_CLIP_PLANES)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (w_load),
        .i_sel     (w_sel),
        .o_coef    (w_coef),
        .o_off     (w_off),
        .o_enabled (w_en)
    );

    afcc_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_ctl   (w_mac),
        .i_coef  (w_coef),
        .i_coord (w_coord),
        .i_off   (w_off),
        .o_below (w_below)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc && (w_kind == KIND_TEST)) begin
                    if (!w_flag) begin
                        n_state = ST_RESULT;
                    end else if (r_camera) begin
                        n_state = ST_FRUST;
                    end else begin
                        n_state = ST_CLIP;
                    end
                end
            end
            ST_FRUST: begin
                if (r_step == STEP_LAST) begin
                    if (w_below) begin
                        n_state = ST_RESULT;
                    end else if (r_fplane == FPLANE_LAST) begin
                        n_state = ST_CLIP;
                    end
                end
            end
            ST_CLIP: begin
                if (!w_en) begin
                    if (w_clast) begin
                        n_state = ST_RESULT;
                    end
                end else if (r_step == STEP_LAST) begin
                    if (w_below || w_clast) begin
                        n_state = ST_RESULT;
                    end
                end
            end
            ST_RESULT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs: MAC controls, plane counters, cause
    assign w_active = (r_state == ST_FRUST) || ((r_state == ST_CLIP) && w_en);

    always_comb begin
        n_step   = r_step;
        n_fplane = r_fplane;
        n_cplane = r_cplane;
        n_cause  = r_cause;
        w_mac.load_off = w_active && (r_step == STEP_FIRST);
        w_mac.mul      = w_active && (r_step != STEP_LAST);
        w_mac.acc      = w_active && ((r_step == STEP_MID1) || (r_step == STEP_MID2));
        case (r_state)
            ST_IDLE: begin
                n_step   = STEP_FIRST;
                n_fplane = '0;
                n_cplane = '0;
                n_cause  = CAUSE_NONE;
            end
            ST_FRUST: begin
                n_step = r_step + 2'd1;
                if (r_step == STEP_LAST) begin
                    if (w_below) begin
                        n_cause = CAUSE_FRUSTUM;
                    end else begin
                        n_fplane = r_fplane + 3'd1;
                    end
                end
            end
            ST_CLIP: begin
                if (!w_en) begin
                    n_step   = STEP_FIRST;
                    n_cplane = r_cplane + 1'b1;
                end else begin
                    n_step = r_step + 2'd1;
                    if (r_step == STEP_LAST) begin
                        if (w_below) begin
                            n_cause = CAUSE_CLIP;
                        end else begin
                            n_cplane = r_cplane + 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_step = r_step;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_step   <= STEP_FIRST;
            r_fplane <= '0;
            r_cplane <= '0;
            r_cause  <= CAUSE_NONE;
            r_camera <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_fplane <= n_fplane;
            r_cplane <= n_cplane;
            r_cause  <= n_cause;
            if (i_cfg_wr_en) begin
                r_camera <= i_cfg_wr_data;
            end
        end
    end

    // Result register: parts the sequencer from a stalled receiver
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_odata  <= '0;
        end else if ((r_state == ST_RESULT) && w_out_free) begin
            r_ovalid <= 1'b1;
            r_odata  <= {r_cause, (r_cause != CAUSE_NONE)};
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    // Box corners held for the whole test
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (w_kind == KIND_TEST)) begin
            for (int i = 0; i < 3; i++) begin
                r_lo[i] <= w_val[i];
                r_hi[i] <= w_val[3 + i];
            end
        end
    end

    // Handshake outputs
    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        m_axis_tvalid = r_ovalid;
        m_axis_tdata  = {5'd0, r_odata};
    end

endmodule
`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the box frustum and clip-plane culler.
`default_nettype none

// Plane store, camera flag and queue of outstanding cull verdicts.
class cull_checker;
    typedef logic signed [79:0] t_wide;   // exact room for three products plus offset
    typedef struct packed {
        logic             culled;
        afcc_pkg::t_cause cause;
    } t_verdict;

    localparam int N_CLIP = afcc_pkg::DEF_MAX_CLIP_PLANES;
    localparam int FRAC   = afcc_pkg::DEF_FRAC_BITS;
    localparam int N_COLS = 4;

    logic signed [31:0] view_mat [16];    // column-major, index col*4 + row
    logic signed [31:0] plane_nx [N_CLIP];
    logic signed [31:0] plane_ny [N_CLIP];
    logic signed [31:0] plane_nz [N_CLIP];
    logic signed [31:0] plane_d  [N_CLIP];
    bit                 plane_on [N_CLIP];
    bit                 camera;
    t_verdict           verdicts_due [$];
    int                 n_errors;
    int                 n_tests;
    int                 n_frustum;
    int                 n_clip;

    function new();
        foreach (view_mat[i]) view_mat[i] = '0;
        for (int k = 0; k < N_CLIP; k++) begin
            plane_nx[k] = '0;
            plane_ny[k] = '0;
            plane_nz[k] = '0;
            plane_d[k]  = '0;
            plane_on[k] = 1'b0;
        end
        camera    = 1'b0;
        n_errors  = 0;
        n_tests   = 0;
        n_frustum = 0;
        n_clip    = 0;
    endfunction

    function int pending();
        return verdicts_due.size();
    endfunction

    // Box wholly on the negative side: pick the corner along the normal
    static function bit beyond_plane(t_wide nx, t_wide ny, t_wide nz, t_wide off,
                                     t_wide lox, t_wide loy, t_wide loz,
                                     t_wide hix, t_wide hiy, t_wide hiz);
        t_wide acc;
        acc = nx * (nx >= 0 ? hix : lox)
            + ny * (ny >= 0 ? hiy : loy)
            + nz * (nz >= 0 ? hiz : loz)
            + (off <<< FRAC);
        return acc < 0;
    endfunction

    function void take_item(afcc_pkg::t_kind kind, logic [2:0] slot, logic flag,
                            logic [5:0][31:0] v);
        t_wide            lo [3];
        t_wide            hi [3];
        t_wide            n  [3];
        t_wide            off;
        t_wide            wa;
        t_wide            wb;
        afcc_pkg::t_cause cause;
        t_verdict         due;
        int               row;
        case (kind)
            afcc_pkg::KIND_LOAD_MAT: begin
                if (int'(slot) < N_COLS)
                    for (int i = 0; i < 4; i++) view_mat[int'(slot) * 4 + i] = v[i];
            end
            afcc_pkg::KIND_LOAD_CLIP: begin
                if (int'(slot) < N_CLIP) begin
                    plane_nx[slot] = v[0];
                    plane_ny[slot] = v[1];
                    plane_nz[slot] = v[2];
                    plane_d[slot]  = v[3];
                    plane_on[slot] = flag;
                end
            end
            afcc_pkg::KIND_TEST: begin
                for (int i = 0; i < 3; i++) begin
                    lo[i] = $signed(v[i]);
                    hi[i] = $signed(v[i + 3]);
                end
                cause = afcc_pkg::CAUSE_NONE;
                if (flag && camera) begin
                    for (int p = 0; p < 6 && cause == afcc_pkg::CAUSE_NONE; p++) begin
                        row = p / 2;
                        for (int j = 0; j < 3; j++) begin
                            wa = view_mat[j * 4 + 3];
                            wb = view_mat[j * 4 + row];
                            n[j] = (p % 2) ? wa - wb : wa + wb;
                        end
                        wa  = view_mat[15];
                        wb  = view_mat[12 + row];
                        off = (p % 2) ? wa - wb : wa + wb;
                        if (beyond_plane(n[0], n[1], n[2], off,
                                         lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]))
                            cause = afcc_pkg::CAUSE_FRUSTUM;
                    end
                end
                if (flag && cause == afcc_pkg::CAUSE_NONE) begin
                    for (int k = 0; k < N_CLIP && cause == afcc_pkg::CAUSE_NONE; k++) begin
                        if (plane_on[k] &&
                            beyond_plane(plane_nx[k], plane_ny[k], plane_nz[k], plane_d[k],
                                         lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]))
                            cause = afcc_pkg::CAUSE_CLIP;
                    end
                end
                due.culled   = (cause != afcc_pkg::CAUSE_NONE);
                due.cause    = cause;
                verdicts_due = {verdicts_due, due};
                n_tests++;
                if (cause == afcc_pkg::CAUSE_FRUSTUM) n_frustum++;
                if (cause == afcc_pkg::CAUSE_CLIP) n_clip++;
            end
            default: ;
        endcase
    endfunction

    function void check_verdict(logic culled, afcc_pkg::t_cause cause);
        t_verdict want;
        if (verdicts_due.size() == 0) begin
            $error("result with no test item waiting: culled %0d cull_cause %0d",
                   culled, cause);
            n_errors++;
            return;
        end
        want = verdicts_due.pop_front();
        if (culled !== want.culled) begin
            $error("culled: expected %0d, got %0d", want.culled, culled);
            n_errors++;
        end
        if (cause !== want.cause) begin
            $error("cull_cause: expected %0d, got %0d", want.cause, cause);
            n_errors++;
        end
    endfunction
endclass

module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import afcc_pkg::*;

    localparam int    CLK_HALF     = 5;
    localparam int    RESET_CYCLES = 11;
    localparam int    CYCLE_LIMIT  = 400000;  // far above the slowest legal run
    localparam int    SETTLE       = 64;      // covers the worst-case test occupancy
    localparam int    DRAIN        = 80;
    localparam int    HALF_ITEMS   = 62;      // effective items per camera setting
    localparam int    Q1           = 65536;   // 1.0 in Q16.16
    localparam t_kind KIND_UNUSED  = 2'd3;
    localparam int    N_COLS       = 4;

    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         i_cfg_wr_en   = 1'b0;
    logic         i_cfg_wr_data = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [199:0] s_axis_tdata  = '0;
    logic [1:0]   s_axis_tuser  = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [7:0]   m_axis_tdata;

    cull_checker  chk = new();
    int           send_idle  = 0;   // per-cent chance the sender holds off
    int           recv_stall = 0;   // per-cent chance the receiver stalls
    int           n_real     = 0;   // items that the block acts upon
    int           cycle_count = 0;

    aabb_frustum_clip_culler u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Receiver back-pressure, redrawn every cycle
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall);
    end

    // Both handshakes sampled at the edge; predictions queue up in order
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            chk.take_item(t_kind'(s_axis_tuser), s_axis_tdata[2:0], s_axis_tdata[3],
                          s_axis_tdata[195:4]);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            chk.check_verdict(m_axis_tdata[0], t_cause'(m_axis_tdata[2:1]));
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // ---- value generators ----

    function automatic logic [31:0] qv(int quarters);
        return quarters * (Q1 / 4);
    endfunction

    // uniform in [-span, span] (Q16.16 raw units)
    function automatic logic [31:0] rand_fix(int span);
        int r;
        r = int'($urandom_range(2 * span)) - span;
        return r;
    endfunction

    function automatic logic [31:0] rand_extreme();
        case ($urandom_range(3))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            default: return 32'h0000_0000;
        endcase
    endfunction

    function automatic logic [31:0] rand_wild();
        return ($urandom_range(99) < 20) ? rand_extreme() : 32'($urandom());
    endfunction

    // ---- drivers ----

    // Present one item, hold it until taken, then maybe hold off the sender
    task automatic push_item(t_kind kind, logic [2:0] slot, logic flag,
                             logic [5:0][31:0] v);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, v, flag, slot};
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
        if (kind != KIND_UNUSED && !(kind == KIND_LOAD_MAT && int'(slot) >= N_COLS))
            n_real++;
        if (send_idle != 0 && $urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle);
        end
    endtask

    task automatic push_box(logic flag, logic [31:0] lx, logic [31:0] ly, logic [31:0] lz,
                            logic [31:0] hx, logic [31:0] hy, logic [31:0] hz);
        push_item(KIND_TEST, 3'($urandom_range(7)), flag, {hz, hy, hx, lz, ly, lx});
    endtask

    task automatic push_col(int col, logic [31:0] r0, logic [31:0] r1,
                            logic [31:0] r2, logic [31:0] r3);
        push_item(KIND_LOAD_MAT, 3'(col), 1'($urandom_range(1)),
                  {32'($urandom()), 32'($urandom()), r3, r2, r1, r0});
    endtask

    task automatic push_clip(int slot, logic en, logic [31:0] nx, logic [31:0] ny,
                             logic [31:0] nz, logic [31:0] d);
        push_item(KIND_LOAD_CLIP, 3'(slot), en,
                  {32'($urandom()), 32'($urandom()), d, nz, ny, nx});
    endtask

    // camera_enable may only change with nothing in flight; valid is dropped and
    // the edge awaited first so that the last accepted item has been noted
    task automatic set_camera(bit on);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (chk.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= on;
        chk.camera = on;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // ---- random sequences ----

    // Roughly perspective-like matrix so that boxes straddle the frustum;
    // now and then a wild one, a skipped column or a stray column index.
    task automatic load_camera_seq();
        logic [31:0] r [4];
        int          start;
        int          c;
        bit          wild;
        start = $urandom_range(3);
        wild  = ($urandom_range(99) < 15);
        for (int i = 0; i < N_COLS; i++) begin
            c = (start + i) % N_COLS;
            for (int k = 0; k < 4; k++) begin
                if (wild)                r[k] = rand_wild();
                else if (k == c && c < 3) r[k] = Q1 / 2 + $urandom_range(3 * Q1 / 2);
                else if (k == 3 && c == 3) r[k] = Q1 + rand_fix(Q1 / 4);
                else if (c == 3)           r[k] = rand_fix(Q1 / 2);
                else if (k == 3)           r[k] = rand_fix(Q1 / 8);
                else                       r[k] = rand_fix(Q1 / 4);
            end
            if ($urandom_range(99) >= 5)
                push_col(c, r[0], r[1], r[2], r[3]);
        end
        if ($urandom_range(99) < 10)
            push_col($urandom_range(N_COLS, 7), rand_wild(), rand_wild(), rand_wild(),
                     rand_wild());
    endtask

    task automatic load_clip_seq();
        bit wild;
        wild = ($urandom_range(99) < 10);
        if (wild)
            push_clip($urandom_range(7), 1'($urandom_range(1)), rand_wild(), rand_wild(),
                      rand_wild(), rand_wild());
        else
            push_clip($urandom_range(7), $urandom_range(99) < 35, rand_fix(Q1),
                      rand_fix(Q1), rand_fix(Q1), rand_fix(2 * Q1));
    endtask

    task automatic random_box();
        logic [31:0] lo [3];
        logic [31:0] hi [3];
        logic [31:0] t;
        logic        flag;
        bit          wild;
        bit          swap;
        flag = ($urandom_range(99) >= 8);
        wild = ($urandom_range(99) < 8);
        swap = ($urandom_range(99) < 10);
        for (int i = 0; i < 3; i++) begin
            if (wild) begin
                lo[i] = rand_wild();
                hi[i] = rand_wild();
            end else begin
                lo[i] = rand_fix(5 * Q1 / 2);
                hi[i] = lo[i] + $urandom_range(3 * Q1 / 2);
            end
            if (swap) begin
                t     = lo[i];
                lo[i] = hi[i];
                hi[i] = t;
            end
        end
        push_box(flag, lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
    endtask

    task automatic noise_item();
        push_item(t_kind'($urandom_range(3)), 3'($urandom_range(7)), 1'($urandom_range(1)),
                  {rand_wild(), rand_wild(), rand_wild(), rand_wild(), rand_wild(),
                   rand_wild()});
    endtask

    // Runs of random boxes, now and then preceded by camera or clip loads or a noise item
    task automatic run_random(int target);
        int start;
        int pick;
        start = n_real;
        while (n_real - start < target) begin
            pick = $urandom_range(99);
            if (pick < 12)
                load_camera_seq();
            else if (pick < 30)
                repeat ($urandom_range(1, 3)) load_clip_seq();
            else if (pick < 40)
                noise_item();
            repeat ($urandom_range(2, 8)) random_box();
        end
    endtask

    // ---- main sequence ----

    int idle_send_tab [4] = '{0, 71, 0, 27};
    int stall_tab     [4] = '{0, 0, 71, 27};

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset state, camera on/off, invalid and inverted
        // boxes, extreme coordinates, disabled planes, stray kinds and slots.
        push_box(1'b1, qv(-4), qv(-4), qv(-4), qv(4), qv(4), qv(4));   // camera off
        set_camera(1'b1);
        push_box(1'b1, qv(8), qv(-1), qv(-1), qv(12), qv(1), qv(1));   // all-zero matrix
        push_col(0, Q1, 0, 0, 0);                                      // identity: unit cube
        push_col(1, 0, Q1, 0, 0);
        push_col(2, 0, 0, Q1, 0);
        push_col(3, 0, 0, 0, Q1);
        push_col(5, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        push_box(1'b1, qv(-2), qv(-2), qv(-2), qv(2), qv(2), qv(2));   // inside
        push_box(1'b1, qv(8), qv(-1), qv(-1), qv(12), qv(1), qv(1));   // beyond x = 1
        push_box(1'b0, qv(8), qv(-1), qv(-1), qv(12), qv(1), qv(1));   // not a valid box
        push_box(1'b1, qv(2), qv(2), qv(2), qv(-2), qv(-2), qv(-2));   // inverted, inside
        push_box(1'b1, qv(12), qv(1), qv(1), qv(8), qv(-1), qv(-1));   // inverted, outside
        push_box(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_box(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        push_clip(7, 1'b1, Q1, 0, 0, 0);                               // keep x >= 0
        push_box(1'b1, qv(-2), qv(-1), qv(-1), qv(-1), qv(1), qv(1));  // clip plane culls
        push_box(1'b1, qv(8), qv(-1), qv(-1), qv(12), qv(1), qv(1));   // frustum culls
        push_clip(0, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        set_camera(1'b0);
        push_box(1'b1, qv(-2), qv(-1), qv(-1), qv(-1), qv(1), qv(1));  // clip only
        push_box(1'b1, qv(8), qv(-1), qv(-1), qv(12), qv(1), qv(1));   // frustum off
        push_item(KIND_UNUSED, 3'd7, 1'b1, {6{32'hFFFF_FFFF}});
        push_clip(7, 1'b0, Q1, 0, 0, 0);
        push_box(1'b1, qv(-2), qv(-1), qv(-1), qv(-1), qv(1), qv(1));  // plane disabled

        // Random: four handshake pressure phases, camera flipped each half
        for (int ph = 0; ph < 4; ph++) begin
            for (int h = 0; h < 2; h++) begin
                set_camera(((ph + h) % 2) == 0);
                send_idle  = idle_send_tab[ph];
                recv_stall = stall_tab[ph];
                run_random(HALF_ITEMS);
            end
        end

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (chk.pending() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        $display("summary: %0d effective items, %0d boxes tested under 4 pressure phases",
                 n_real, chk.n_tests);
        $display("summary: %0d culled by frustum, %0d by clip planes, %0d mismatches",
                 chk.n_frustum, chk.n_clip, chk.n_errors);
        if (chk.n_errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule
`default_nettype wire
